// ===== rtl/core/ecf_pkg.sv =====
// Shared constants for the Euler circuit finder.
package ecf_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MAX_EDGES    = 63;
    localparam int WALK_DEPTH   = 64;

    localparam int VERTEX_W = 4;
    localparam int VCOUNT_W = 5;
    localparam int EDGE_W   = 6;
    localparam int DEPTH_W  = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [EDGE_W-1:0]   LIST_EMPTY     = EDGE_W'(63);
    localparam logic [EDGE_W-1:0]   EDGES_FULL     = EDGE_W'(MAX_EDGES);
    localparam logic [VCOUNT_W-1:0] VCOUNT_MAX     = VCOUNT_W'(MAX_VERTICES);
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET   = VCOUNT_W'(16);
    localparam logic [DEPTH_W-1:0]  DEPTH_FULL     = DEPTH_W'(WALK_DEPTH);

    // Register index, taken from paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef logic [VERTEX_W-1:0] t_vertex;
    typedef logic [EDGE_W-1:0]   t_edge_idx;

    typedef struct packed {
        t_vertex   dest;
        t_edge_idx link;
    } t_edge;

endpackage

// ===== rtl/core/euler_circuit_finder.sv =====
// Euler circuit finder: edge loader, Hierholzer walk sequencer and tour emitter.
//
// Input channel (i_in_valid / o_in_stall) carries one directed edge per
// transaction; an edge with a vertex at or above vertex_count, or arriving
// when the edge store is full, is dropped and sets edges_dropped. A transaction
// with last_item starts the walk from vertex 0; o_in_stall is high from then
// until the final tour vertex has been placed in the output register.
// Loading never stalls the input channel. The walk takes each edge and
// retires each vertex with one pass through the head table and one
// registered read of the edge or path store; emission then reads each
// vertex through the tour buffer read port.
// Output channel (o_out_valid / i_out_stall) delivers the tour in walking
// order with last_out on the final vertex; a stalled result holds in the
// output register and emission pauses behind it. A graph with vertex_count
// zero emits nothing. vertex_count is written over the APB port; the user must
// write it only while idle: the block itself does not enforce it. Synchronous reset
// clears the graph, the sequencer and the output valid flag and sets vertex_count to 16.
module euler_circuit_finder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ecf_pkg::PADDR_W-1:0]     paddr,
    input  logic [ecf_pkg::PDATA_W-1:0]     pwdata,
    output logic [ecf_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ecf_pkg::VERTEX_W-1:0]    i_src_vertex,
    input  logic [ecf_pkg::VERTEX_W-1:0]    i_dst_vertex,
    input  logic                            i_edge_present,
    input  logic                            i_last_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ecf_pkg::VERTEX_W-1:0]    o_tour_vertex,
    output logic                            o_last_out,
    output logic                            o_edges_dropped
);
    import ecf_pkg::*;

    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_WALK_HEAD = 3'd1;
    localparam logic [2:0] S_WALK_EDGE = 3'd2;
    localparam logic [2:0] S_WALK_POP  = 3'd3;
    localparam logic [2:0] S_EMIT_RD   = 3'd4;
    localparam logic [2:0] S_EMIT_LD   = 3'd5;

    logic [2:0]          r_state, n_state;
    t_edge_idx           r_head [MAX_VERTICES];
    t_edge_idx           n_head [MAX_VERTICES];
    t_edge_idx           r_edges_stored, n_edges_stored;
    logic                r_drop, n_drop;
    t_vertex             r_cur, n_cur;
    logic [DEPTH_W-1:0]  r_stack_top, n_stack_top;
    logic [DEPTH_W-1:0]  r_tour_len, n_tour_len;
    logic [EDGE_W-1:0]   r_emit_idx, n_emit_idx;
    logic [VCOUNT_W-1:0] r_vertex_count;
    logic                r_out_valid, n_out_valid;
    t_vertex             r_out_vertex, n_out_vertex;
    logic                r_out_last, n_out_last;
    logic                r_out_drop, n_out_drop;

    t_edge               mem_edge  [MAX_EDGES];
    t_vertex             mem_stack [WALK_DEPTH];
    t_vertex             mem_tour  [WALK_DEPTH];
    t_edge               r_edge_q;
    t_vertex             r_stack_q;
    t_vertex             r_tour_q;

    logic                edge_wr;
    t_edge               edge_wr_data;
    logic                stack_wr;
    logic                tour_wr;

    logic [VCOUNT_W-1:0] nv;
    t_vertex             head_addr;
    t_edge_idx           head_q;
    logic                in_accept;
    logic                edge_ok;
    logic                out_load;
    logic [DEPTH_W-1:0]  stack_dec;
    logic                cfg_wr;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_VERTEX_COUNT);
    assign prdata = (paddr[2] == REG_VERTEX_COUNT)
                  ? {{(PDATA_W-VCOUNT_W){1'b0}}, r_vertex_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (cfg_wr) begin
            r_vertex_count <= pwdata[VCOUNT_W-1:0];
        end
    end

    assign nv        = (r_vertex_count > VCOUNT_MAX) ? VCOUNT_MAX : r_vertex_count;
    assign head_addr = (r_state == S_LOAD) ? i_src_vertex : r_cur;
    assign head_q    = r_head[head_addr];
    assign in_accept = i_in_valid & ~o_in_stall;
    assign edge_ok   = ({1'b0, i_src_vertex} < nv) && ({1'b0, i_dst_vertex} < nv)
                    && (r_edges_stored != EDGES_FULL);
    assign out_load  = (r_state == S_EMIT_LD) && (!r_out_valid || !i_out_stall);
    assign stack_dec = r_stack_top - DEPTH_W'(1);
    assign edge_wr_data = '{dest: i_dst_vertex, link: head_q};

    assign o_in_stall      = (r_state != S_LOAD);
    assign o_out_valid     = r_out_valid;
    assign o_tour_vertex   = r_out_vertex;
    assign o_last_out      = r_out_last;
    assign o_edges_dropped = r_out_drop;

    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_edges_stored = r_edges_stored;
        n_drop         = r_drop;
        n_cur          = r_cur;
        n_stack_top    = r_stack_top;
        n_tour_len     = r_tour_len;
        n_emit_idx     = r_emit_idx;
        n_out_valid    = r_out_valid & i_out_stall;
        n_out_vertex   = r_out_vertex;
        n_out_last     = r_out_last;
        n_out_drop     = r_out_drop;
        edge_wr        = 1'b0;
        stack_wr       = 1'b0;
        tour_wr        = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (in_accept) begin
                    if (i_edge_present) begin
                        if (edge_ok) begin
                            edge_wr                = 1'b1;
                            n_head[i_src_vertex]   = r_edges_stored;
                            n_edges_stored         = r_edges_stored + EDGE_W'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    if (i_last_item) begin
                        if (nv != '0) begin
                            n_state     = S_WALK_HEAD;
                            n_cur       = '0;
                            n_stack_top = DEPTH_W'(1);
                            n_tour_len  = '0;
                        end else begin
                            for (int v = 0; v < MAX_VERTICES; v++) begin
                                n_head[v] = LIST_EMPTY;
                            end
                            n_edges_stored = '0;
                            n_drop         = 1'b0;
                        end
                    end
                end
            end
            S_WALK_HEAD: begin
                if (head_q != LIST_EMPTY) begin
                    if (r_stack_top != DEPTH_FULL) begin
                        stack_wr    = 1'b1;
                        n_stack_top = r_stack_top + DEPTH_W'(1);
                    end
                    n_state = S_WALK_EDGE;
                end else begin
                    if (r_tour_len != DEPTH_FULL) begin
                        tour_wr    = 1'b1;
                        n_tour_len = r_tour_len + DEPTH_W'(1);
                    end
                    n_stack_top = stack_dec;
                    n_state     = S_WALK_POP;
                end
            end
            S_WALK_EDGE: begin
                n_head[r_cur] = r_edge_q.link;
                n_cur         = r_edge_q.dest;
                n_state       = S_WALK_HEAD;
            end
            S_WALK_POP: begin
                if (r_stack_top == '0) begin
                    n_emit_idx = r_tour_len[EDGE_W-1:0] - EDGE_W'(1);
                    n_state    = S_EMIT_RD;
                end else begin
                    n_cur   = r_stack_q;
                    n_state = S_WALK_HEAD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_vertex = r_tour_q;
                    n_out_last   = (r_emit_idx == '0);
                    n_out_drop   = r_drop;
                    if (r_emit_idx == '0) begin
                        for (int v = 0; v < MAX_VERTICES; v++) begin
                            n_head[v] = LIST_EMPTY;
                        end
                        n_edges_stored = '0;
                        n_drop         = 1'b0;
                        n_stack_top    = '0;
                        n_tour_len     = '0;
                        n_cur          = '0;
                        n_state        = S_LOAD;
                    end else begin
                        n_emit_idx = r_emit_idx - EDGE_W'(1);
                        n_state    = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_LOAD;
            r_edges_stored <= '0;
            r_drop         <= 1'b0;
            r_cur          <= '0;
            r_stack_top    <= '0;
            r_tour_len     <= '0;
            r_emit_idx     <= '0;
            r_out_valid    <= 1'b0;
            for (int v = 0; v < MAX_VERTICES; v++) begin
                r_head[v] <= LIST_EMPTY;
            end
        end else begin
            r_state        <= n_state;
            r_edges_stored <= n_edges_stored;
            r_drop         <= n_drop;
            r_cur          <= n_cur;
            r_stack_top    <= n_stack_top;
            r_tour_len     <= n_tour_len;
            r_emit_idx     <= n_emit_idx;
            r_out_valid    <= n_out_valid;
            r_head         <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_vertex <= n_out_vertex;
        r_out_last   <= n_out_last;
        r_out_drop   <= n_out_drop;
    end

    // Edge store: written while loading, read at the list head during the walk
    always_ff @(posedge i_clk) begin
        if (edge_wr) begin
            mem_edge[r_edges_stored] <= edge_wr_data;
        end
        r_edge_q <= mem_edge[head_q];
    end

    // Path stack: entry 0 is never written and the value read from it is never used
    always_ff @(posedge i_clk) begin
        if (stack_wr) begin
            mem_stack[r_stack_top[EDGE_W-1:0]] <= r_cur;
        end
        r_stack_q <= mem_stack[stack_dec[EDGE_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (tour_wr) begin
            mem_tour[r_tour_len[EDGE_W-1:0]] <= r_cur;
        end
        r_tour_q <= mem_tour[r_emit_idx];
    end

    // Each retired vertex pairs with a taken edge, bar the first
    a_tour_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_tour_len <= ({1'b0, r_edges_stored} + DEPTH_W'(1))))
        else $error("tour longer than stored edges allow");

    a_stack_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_HEAD) |-> (r_stack_top != '0))
        else $error("walk step with empty path stack");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_emit_idx == '0)) |=>
            (r_state == S_LOAD) && o_out_valid && o_last_out && (r_edges_stored == '0))
        else $error("final vertex did not close the graph");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_POP && r_stack_top == '0) |-> (r_tour_len != '0))
        else $error("walk ended with an empty tour");

endmodule
